// ===== design/tcw_pkg.sv =====
// Package for the text console writer: geometry, character codes, command codes
// and the control/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // Widths: ports are fixed; the store address follows the geometry
   localparam int CMD_W  = 2;
   localparam int CHAR_W = 8;
   localparam int IDX_W  = 11;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CELL_W = 2 * CHAR_W;
   localparam int ADDR_W = $clog2(CELLS);

   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'd15;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_INIT,   // write space, reset colour at counter
      MEM_FILL,   // write space, current colour at counter
      MEM_COPY,   // read at counter, write lands one row up next cycle
      MEM_CHAR,   // write character at cursor
      MEM_READ    // read requested cell
   } mem_op_type;

   typedef enum logic [2:0] {
      CNT_HOLD,
      CNT_ZERO,
      CNT_ROWSTART,
      CNT_LASTROW,
      CNT_INC
   } cnt_op_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_NEWLINE,
      CUR_ADV
   } cur_op_type;

   typedef struct packed {
      logic       load_item;
      cnt_op_type cnt_op;
      mem_op_type mem_op;
      cur_op_type cur_op;
      logic       rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             is_newline;
      logic             col_full;
      logic             row_last;
      logic             cnt_last;
      logic             out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/tcw_ctrl.sv =====
// Controller state machine for the text console writer.
// Depends on tcw_pkg; drives tcw_datapath through ctl_cmd_type.
`default_nettype none

module tcw_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire tcw_pkg::dp_status_type status,
   output tcw_pkg::ctl_cmd_type        cmd
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_COPY,
      S_DRAIN,
      S_FILL,
      S_WRITE,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.load_item = 1'b0;
      cmd.cnt_op    = CNT_HOLD;
      cmd.mem_op    = MEM_NONE;
      cmd.cur_op    = CUR_HOLD;
      cmd.rsp_load  = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.mem_op = MEM_INIT;
            cmd.cnt_op = CNT_INC;
            if (status.cnt_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            priority case (status.cmd)
               CMD_PUT: begin
                  if (status.is_newline || status.col_full) begin
                     cmd.cur_op = CUR_NEWLINE;
                     if (status.row_last) begin
                        cmd.cnt_op = CNT_ROWSTART;
                        state_in   = S_COPY;
                     end else if (status.is_newline) begin
                        state_in = S_RESP;
                     end else begin
                        state_in = S_WRITE;
                     end
                  end else begin
                     state_in = S_WRITE;
                  end
               end
               CMD_CLEAR: begin
                  cmd.cnt_op = CNT_ZERO;
                  state_in   = S_FILL;
               end
               CMD_READ: begin
                  cmd.mem_op = MEM_READ;
                  state_in   = S_RESP;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_COPY: begin
            cmd.mem_op = MEM_COPY;
            cmd.cnt_op = CNT_INC;
            if (status.cnt_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // last copy write lands here
            cmd.cnt_op = CNT_LASTROW;
            state_in   = S_FILL;
         end
         S_FILL: begin
            cmd.mem_op = MEM_FILL;
            cmd.cnt_op = CNT_INC;
            if (status.cnt_last) begin
               if (status.cmd == CMD_PUT && !status.is_newline) state_in = S_WRITE;
               else                                               state_in = S_RESP;
            end
         end
         S_WRITE: begin
            cmd.mem_op = MEM_CHAR;
            cmd.cur_op = CUR_ADV;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else       state_ff <= state_in;
   end

   assign req_stall = (state_ff != S_IDLE);

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is still in flight");

   a_rsp_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.out_free)
      else $error("result loaded over an untaken word");

   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("input accepted during the clearing pass");

endmodule

`default_nettype wire

// ===== design/tcw_datapath.sv =====
// Datapath for the text console writer: screen store, cursor, colour register,
// sweep counter, item and result registers. Depends on tcw_pkg.
`default_nettype none

module tcw_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tcw_pkg::ctl_cmd_type         cmd,
   output tcw_pkg::dp_status_type            status,
   input  wire logic                         csr_wr_en,
   input  wire logic [tcw_pkg::CHAR_W-1:0]   csr_wr_data,
   input  wire logic [tcw_pkg::CMD_W-1:0]    req_command,
   input  wire logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  wire logic [tcw_pkg::IDX_W-1:0]    req_cell_index,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [tcw_pkg::CHAR_W-1:0]        rsp_cell_char,
   output logic [tcw_pkg::CHAR_W-1:0]        rsp_cell_color,
   output logic [tcw_pkg::ROW_W-1:0]         rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]         rsp_cursor_col
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] screen_mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data;

   logic [CMD_W-1:0]  cmd_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              in_range_ff;

   logic [CHAR_W-1:0] color_ff;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              cp_wr_ff;
   logic [ADDR_W-1:0] cp_addr_ff;
   logic [ADDR_W-1:0] char_addr;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_color_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;

   logic row_last, col_full;

   assign row_last  = (cur_row_ff == ROW_W'(ROWS - 1));
   assign col_full  = (cur_col_ff >= COL_W'(COLUMNS));
   assign char_addr = ADDR_W'(cur_row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_ff);

   assign status.cmd        = cmd_ff;
   assign status.is_newline = (char_ff == NEWLINE_CODE);
   assign status.col_full   = col_full;
   assign status.row_last   = row_last;
   assign status.cnt_last   = (cnt_ff == ADDR_W'(CELLS - 1));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // store port selection; a pending copy write never meets another write
   always_comb begin
      wr_en   = cp_wr_ff;
      wr_addr = cp_addr_ff;
      wr_data = rd_data_ff;
      rd_en   = 1'b0;
      rd_addr = cnt_ff;
      unique case (cmd.mem_op)
         MEM_NONE: ;
         MEM_INIT: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = {RESET_COLOR, SPACE_CODE};
         end
         MEM_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = {color_ff, SPACE_CODE};
         end
         MEM_CHAR: begin
            wr_en   = 1'b1;
            wr_addr = char_addr;
            wr_data = {color_ff, char_ff};
         end
         MEM_COPY: rd_en = 1'b1;
         MEM_READ: begin
            rd_en   = in_range_ff;
            rd_addr = ADDR_W'(idx_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) screen_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= screen_mem[rd_addr];
   end

   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      unique case (cmd.cur_op)
         CUR_HOLD: ;
         CUR_NEWLINE: begin
            cur_col_in = '0;
            if (!row_last) cur_row_in = cur_row_ff + 1'b1;
         end
         CUR_ADV: cur_col_in = cur_col_ff + 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      unique case (cmd.cnt_op)
         CNT_HOLD:     cnt_in = cnt_ff;
         CNT_ZERO:     cnt_in = '0;
         CNT_ROWSTART: cnt_in = ADDR_W'(COLUMNS);
         CNT_LASTROW:  cnt_in = ADDR_W'((ROWS - 1) * COLUMNS);
         CNT_INC:      cnt_in = cnt_ff + 1'b1;
         default:      cnt_in = cnt_ff;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load)                   rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else                                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= RESET_COLOR;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         cnt_ff       <= '0;
         cp_wr_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) color_ff <= csr_wr_data;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         cnt_ff       <= cnt_in;
         cp_wr_ff     <= (cmd.mem_op == MEM_COPY);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cp_addr_ff <= cnt_ff - ADDR_W'(COLUMNS);
      if (cmd.load_item) begin
         cmd_ff      <= req_command;
         char_ff     <= req_char_code;
         idx_ff      <= req_cell_index;
         in_range_ff <= ({1'b0, req_cell_index} < (IDX_W + 1)'(CELLS));
      end
      if (cmd.rsp_load) begin
         if (cmd_ff == CMD_READ && in_range_ff) begin
            rsp_char_ff  <= rd_data_ff[CHAR_W-1:0];
            rsp_color_ff <= rd_data_ff[CELL_W-1:CHAR_W];
         end else begin
            rsp_char_ff  <= '0;
            rsp_color_ff <= '0;
         end
         rsp_row_ff <= cur_row_ff;
         rsp_col_ff <= cur_col_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_color = rsp_color_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      cp_wr_ff |-> (cmd.mem_op != MEM_INIT && cmd.mem_op != MEM_FILL
                    && cmd.mem_op != MEM_CHAR))
      else $error("scroll copy write collides with another store write");

   a_char_in_row: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_op == MEM_CHAR) |-> (cur_col_ff < COL_W'(COLUMNS)))
      else $error("character written past the end of the row");

   a_cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      (cur_row_ff < ROW_W'(ROWS)) && (cur_col_ff <= COL_W'(COLUMNS)))
      else $error("cursor outside the screen");

endmodule

`default_nettype wire

// ===== design/text_console_writer_core.sv =====
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
`default_nettype none

// Text console writer, 80 columns by 25 rows. Each cell of the screen store
// holds a character byte and an attribute byte (foreground low nibble,
// background high nibble); the attribute for writes, clears and the scroll
// fill comes from the one colour register (csr_wr_en / csr_wr_data, reset 15).
// Command 0 prints req_char_code at the cursor (code 10 starts a new line; a
// printable character on a full row wraps first), 1 blanks the whole screen
// and leaves the cursor alone, 2 reads cell req_cell_index, 3 does nothing.
// Every accepted word gives exactly one result word carrying the cursor after
// the command, and the cell contents for an in-range read (zero otherwise).
// The block takes one word at a time. A clear blanks the store one cell per cycle;
// a line feed on the bottom row (or a wrap there) scrolls: every cell below the
// top row is copied one row up, the last copy write lands in a drain state, and
// the bottom row is blanked, before a following character is written. After
// reset the store is blanked in a pass with req_stall high; colour register
// writes are still taken then. A finished result sits in the output register,
// so the next word may be taken while rsp_stall holds it.

module text_console_writer_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [tcw_pkg::CHAR_W-1:0] csr_wr_data,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [tcw_pkg::CMD_W-1:0]  req_command,
   input  wire logic [tcw_pkg::CHAR_W-1:0] req_char_code,
   input  wire logic [tcw_pkg::IDX_W-1:0]  req_cell_index,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [tcw_pkg::CHAR_W-1:0]      rsp_cell_char,
   output logic [tcw_pkg::CHAR_W-1:0]      rsp_cell_color,
   output logic [tcw_pkg::ROW_W-1:0]       rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]       rsp_cursor_col
);
   import tcw_pkg::*;

   // command and status between the two halves
   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (ctl_cmd)
   );

   tcw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctl_cmd),
      .status         (dp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_command    (req_command),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_color (rsp_cell_color),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col)
   );

endmodule

`default_nettype wire
